// ----- rtl/key_press_duration_tracker_defines.svh -----
// assertion macros for the key press duration tracker checker
// no dependencies; included by files that hold concurrent assertions
`ifndef KEY_PRESS_DURATION_TRACKER_DEFINES_SVH
`define KEY_PRESS_DURATION_TRACKER_DEFINES_SVH

// property checked on every rising clock edge outside reset
`define KPDT_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked on every rising clock edge outside reset
`define KPDT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- rtl/kpdt_pkg.sv -----
// shared types, constants and helpers of the key press duration tracker
// no dependencies
package kpdt_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = $clog2(2 * QUEUE_DEPTH);

    localparam logic [31:0] MAX_HOLD_RESET = 32'd1000;

    localparam logic [1:0] KIND_TAP     = 2'd0;
    localparam logic [1:0] KIND_TIMEOUT = 2'd1;
    localparam logic [1:0] KIND_DROP    = 2'd2;

    typedef struct packed {
        logic [4:0] layer;
        logic [3:0] row;
        logic [4:0] col;
    } key_t;

    typedef struct packed {
        key_t        key;
        logic        done;
        logic [31:0] start;
        logic [31:0] gap;
        logic [31:0] hold;
    } entry_t;

    typedef struct packed {
        logic [4:0]  col;
        logic [3:0]  row;
        logic [4:0]  layer;
        logic [31:0] hold;
        logic [31:0] gap;
        logic [1:0]  kind;
        logic        last;
    } result_t;

    typedef struct packed {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        entry_t           wr_data;
    } mem_req_t;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] hold;
        logic        use_hold;
    } alu_req_t;

    typedef struct packed {
        logic [31:0] diff;
        logic [31:0] value;
        logic        gt;
    } alu_rsp_t;

    // ring slot at an offset from the head
    function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
                                                 input logic [CNT_W-1:0] off);
        logic [SUM_W-1:0] s;
        s = SUM_W'(head) + SUM_W'(off);
        if (s >= SUM_W'(QUEUE_DEPTH))
        begin
            s = s - SUM_W'(QUEUE_DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

endpackage

// ----- rtl/kpdt_ifs.sv -----
// valid/ready channel interfaces: key events in, results out, config writes
// no dependencies
interface kpdt_evt_if;
    logic        valid;
    logic        ready;
    logic        cmd;
    logic [4:0]  key_col;
    logic [3:0]  key_row;
    logic [4:0]  key_layer;
    logic [31:0] now_ms;

    modport source (output valid, cmd, key_col, key_row, key_layer, now_ms, input ready);
    modport sink   (input valid, cmd, key_col, key_row, key_layer, now_ms, output ready);
endinterface

interface kpdt_tap_if;
    logic        valid;
    logic        ready;
    logic [4:0]  tap_col;
    logic [3:0]  tap_row;
    logic [4:0]  tap_layer;
    logic [31:0] hold_ms;
    logic [31:0] gap_ms;
    logic [1:0]  kind;
    logic        last;

    modport source (output valid, tap_col, tap_row, tap_layer, hold_ms, gap_ms, kind, last,
                    input ready);
    modport sink   (input valid, tap_col, tap_row, tap_layer, hold_ms, gap_ms, kind, last,
                    output ready);
endinterface

interface kpdt_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

// ----- rtl/kpdt_alu.sv -----
// shared 32-bit subtract and limit compare used by the release scan, head retirement and press append steps
// depends on kpdt_pkg
module kpdt_alu (
    input  kpdt_pkg::alu_req_t req,
    input  logic [31:0]        limit,
    output kpdt_pkg::alu_rsp_t rsp
);
    import kpdt_pkg::*;

    always_comb
    begin
        rsp.diff  = req.a - req.b;
        rsp.value = req.use_hold ? req.hold : rsp.diff;
        rsp.gt    = rsp.value > limit;
    end

endmodule

// ----- rtl/kpdt_queue_mem.sv -----
// entry ring storage, one write and one registered read per cycle
// depends on kpdt_pkg
module kpdt_queue_mem (
    input  logic               clk,
    input  kpdt_pkg::mem_req_t req,
    output kpdt_pkg::entry_t   rd_data
);
    import kpdt_pkg::*;

    entry_t entry_mem [QUEUE_DEPTH];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            entry_mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= entry_mem[req.rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/kpdt_seq.sv -----
// event sequencer: release scan, head retirement, press append, result staging
// depends on kpdt_pkg, kpdt_ifs, drives kpdt_queue_mem and kpdt_alu
module kpdt_seq (
    input  logic               clk,
    input  logic               rst_n,
    kpdt_evt_if.sink           evt,
    kpdt_tap_if.source         tap,
    output kpdt_pkg::mem_req_t mem_req,
    input  kpdt_pkg::entry_t   rd_data,
    output kpdt_pkg::alu_req_t alu_req,
    input  kpdt_pkg::alu_rsp_t alu_rsp
);
    import kpdt_pkg::*;

    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_SCAN_RD  = 3'd1;
    localparam logic [2:0] ST_SCAN_CHK = 3'd2;
    localparam logic [2:0] ST_RET_RD   = 3'd3;
    localparam logic [2:0] ST_RET_CHK  = 3'd4;
    localparam logic [2:0] ST_POST     = 3'd5;
    localparam logic [2:0] ST_FLUSH    = 3'd6;

    logic [2:0]       state_reg, state_next;
    logic             cmd_reg, cmd_next;
    key_t             key_reg, key_next;
    logic [31:0]      now_reg, now_next;
    logic             seen_reg, seen_next;
    logic [31:0]      prev_reg, prev_next;
    logic [IDX_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    result_t          pend_reg, pend_next;
    logic             pend_valid_reg, pend_valid_next;
    result_t          out_reg, out_next;
    logic             out_valid_reg, out_valid_next;

    logic can_push;
    logic push;
    logic push_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            seen_reg       <= 1'b0;
            prev_reg       <= '0;
            head_reg       <= '0;
            count_reg      <= '0;
            idx_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            seen_reg       <= seen_next;
            prev_reg       <= prev_next;
            head_reg       <= head_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg  <= cmd_next;
        key_reg  <= key_next;
        now_reg  <= now_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    // shared unit operands
    always_comb
    begin
        alu_req.a        = now_reg;
        alu_req.b        = (state_reg == ST_POST) ? prev_reg : rd_data.start;
        alu_req.hold     = rd_data.hold;
        alu_req.use_hold = rd_data.done;
    end

    assign can_push = !out_valid_reg || tap.ready;

    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        now_next        = now_reg;
        seen_next       = seen_reg;
        prev_next       = prev_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        push            = 1'b0;
        push_last       = 1'b0;

        mem_req         = '0;
        mem_req.rd_addr = head_reg;
        mem_req.wr_addr = slot_of(head_reg, count_reg);
        mem_req.wr_data = rd_data;

        if (out_valid_reg && tap.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (evt.valid)
                begin
                    cmd_next  = evt.cmd;
                    key_next  = '{layer: evt.key_layer, row: evt.key_row, col: evt.key_col};
                    now_next  = evt.now_ms;
                    idx_next  = '0;
                    if (!seen_reg)
                    begin
                        seen_next = 1'b1;
                        prev_next = evt.now_ms;
                    end
                    if (!evt.cmd && count_reg != '0)
                    begin
                        state_next = ST_SCAN_RD;
                    end
                    else
                    begin
                        state_next = ST_RET_RD;
                    end
                end
            end
            ST_SCAN_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    state_next = ST_RET_RD;
                end
                else
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = slot_of(head_reg, idx_reg);
                    state_next      = ST_SCAN_CHK;
                end
            end
            ST_SCAN_CHK:
            begin
                // oldest open entry of the same matrix position takes the release
                if (!rd_data.done && rd_data.key.col == key_reg.col
                    && rd_data.key.row == key_reg.row)
                begin
                    mem_req.wr_en        = 1'b1;
                    mem_req.wr_addr      = slot_of(head_reg, idx_reg);
                    mem_req.wr_data.done = 1'b1;
                    mem_req.wr_data.hold = alu_rsp.diff;
                    state_next           = ST_RET_RD;
                end
                else
                begin
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = ST_SCAN_RD;
                end
            end
            ST_RET_RD:
            begin
                if (count_reg == '0)
                begin
                    state_next = ST_POST;
                end
                else
                begin
                    mem_req.rd_en   = 1'b1;
                    mem_req.rd_addr = head_reg;
                    state_next      = ST_RET_CHK;
                end
            end
            ST_RET_CHK:
            begin
                if (!rd_data.done && !alu_rsp.gt)
                begin
                    state_next = ST_POST;
                end
                else if (!pend_valid_reg || can_push)
                begin
                    push            = pend_valid_reg;
                    pend_next.col   = rd_data.key.col;
                    pend_next.row   = rd_data.key.row;
                    pend_next.layer = rd_data.key.layer;
                    pend_next.hold  = alu_rsp.value;
                    pend_next.gap   = rd_data.gap;
                    pend_next.kind  = alu_rsp.gt ? KIND_TIMEOUT : KIND_TAP;
                    pend_next.last  = 1'b0;
                    pend_valid_next = 1'b1;
                    head_next       = slot_of(head_reg, CNT_W'(1));
                    count_next      = count_reg - CNT_W'(1);
                    state_next      = ST_RET_RD;
                end
            end
            ST_POST:
            begin
                if (!cmd_reg)
                begin
                    state_next = ST_FLUSH;
                end
                else if (count_reg == CNT_W'(QUEUE_DEPTH))
                begin
                    // queue full: report the press as dropped
                    if (!pend_valid_reg || can_push)
                    begin
                        push            = pend_valid_reg;
                        prev_next       = now_reg;
                        pend_next.col   = key_reg.col;
                        pend_next.row   = key_reg.row;
                        pend_next.layer = key_reg.layer;
                        pend_next.hold  = '0;
                        pend_next.gap   = alu_rsp.diff;
                        pend_next.kind  = KIND_DROP;
                        pend_next.last  = 1'b0;
                        pend_valid_next = 1'b1;
                        state_next      = ST_FLUSH;
                    end
                end
                else
                begin
                    prev_next             = now_reg;
                    mem_req.wr_en         = 1'b1;
                    mem_req.wr_addr       = slot_of(head_reg, count_reg);
                    mem_req.wr_data.key   = key_reg;
                    mem_req.wr_data.done  = 1'b0;
                    mem_req.wr_data.start = now_reg;
                    mem_req.wr_data.gap   = alu_rsp.diff;
                    mem_req.wr_data.hold  = '0;
                    count_next            = count_reg + CNT_W'(1);
                    state_next            = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (can_push)
                begin
                    push            = 1'b1;
                    push_last       = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (push)
        begin
            out_next       = pend_reg;
            out_next.last  = push_last;
            out_valid_next = 1'b1;
        end
    end

    assign evt.ready     = (state_reg == ST_IDLE);
    assign tap.valid     = out_valid_reg;
    assign tap.tap_col   = out_reg.col;
    assign tap.tap_row   = out_reg.row;
    assign tap.tap_layer = out_reg.layer;
    assign tap.hold_ms   = out_reg.hold;
    assign tap.gap_ms    = out_reg.gap;
    assign tap.kind      = out_reg.kind;
    assign tap.last      = out_reg.last;

endmodule

// ----- rtl/key_press_duration_tracker.sv -----
// Key press duration tracker. Each key event is accepted, then for a release the scan reads
// queued entries from the head, each read followed by a check, until one matches or all are
// checked; then entries are read and checked at the head and retired until an open entry
// within the limit stops retirement or the queue drains; then the press is appended or,
// if the queue is full, dropped (a release skips this step), and the final word is flushed.
// The result channel can stall each result word. The entry store has a single read port whose
// read data is registered before the shared subtract and limit compare act on it.
// The event channel is ready only between events; the config channel is always ready
// and must be written only while the block is idle.
// depends on kpdt_pkg, kpdt_ifs, kpdt_alu, kpdt_queue_mem, kpdt_seq
module key_press_duration_tracker (
    input  logic       clk,
    input  logic       rst_n,
    kpdt_evt_if.sink   evt,
    kpdt_tap_if.source tap,
    kpdt_cfg_if.sink   cfg
);
    import kpdt_pkg::*;

    logic [31:0] max_hold_reg;
    mem_req_t    mem_req;
    entry_t      rd_data;
    alu_req_t    alu_req;
    alu_rsp_t    alu_rsp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_hold_reg <= MAX_HOLD_RESET;
        end
        else if (cfg.valid)
        begin
            max_hold_reg <= cfg.data;
        end
    end

    assign cfg.ready = 1'b1;

    kpdt_queue_mem u_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    kpdt_alu u_alu (
        .req   (alu_req),
        .limit (max_hold_reg),
        .rsp   (alu_rsp)
    );

    kpdt_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .evt     (evt),
        .tap     (tap),
        .mem_req (mem_req),
        .rd_data (rd_data),
        .alu_req (alu_req),
        .alu_rsp (alu_rsp)
    );

endmodule

// ----- rtl/kpdt_checker.sv -----
// port-level checks of the key press duration tracker, bound to the top level
// depends on kpdt_pkg and key_press_duration_tracker_defines.svh
`include "key_press_duration_tracker_defines.svh"

module kpdt_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        evt_valid,
    input logic        evt_ready,
    input logic        tap_valid,
    input logic        tap_ready,
    input logic [31:0] tap_hold_ms,
    input logic [31:0] tap_gap_ms,
    input logic [1:0]  tap_kind,
    input logic        tap_last
);
    import kpdt_pkg::*;

    // stalled word holds
    `KPDT_ASSERT(a_tap_hold, clk, rst_n, tap_valid && !tap_ready |=> tap_valid && $stable(tap_hold_ms) && $stable(tap_gap_ms) && $stable(tap_kind) && $stable(tap_last), "stalled result word changed")
    // busy right after an event is taken
    `KPDT_ASSERT(a_busy_after_evt, clk, rst_n, evt_valid && evt_ready |=> !evt_ready, "event accepted while busy")
    // dropped press closes its event with zero hold
    `KPDT_ASSERT_IMP(a_drop_last, clk, rst_n, tap_valid && tap_kind == KIND_DROP, tap_last && tap_hold_ms == '0, "dropped press word malformed")
    // only defined kinds leave the block
    `KPDT_ASSERT_IMP(a_kind_code, clk, rst_n, tap_valid, tap_kind == KIND_TAP || tap_kind == KIND_TIMEOUT || tap_kind == KIND_DROP, "undefined result kind")

endmodule

bind key_press_duration_tracker kpdt_checker u_kpdt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .evt_valid   (evt.valid),
    .evt_ready   (evt.ready),
    .tap_valid   (tap.valid),
    .tap_ready   (tap.ready),
    .tap_hold_ms (tap.hold_ms),
    .tap_gap_ms  (tap.gap_ms),
    .tap_kind    (tap.kind),
    .tap_last    (tap.last)
);

// ----- tb/key_press_duration_tracker_test.sv -----
`timescale 1ns / 100ps
// testbench of the key press duration tracker: directed and random key event streams,
// every result word checked against an in-bench tracking model, partly under random backpressure
// depends on kpdt_pkg, kpdt_ifs and key_press_duration_tracker
module key_press_duration_tracker_test;

    localparam logic CMD_RELEASE = 1'b0;
    localparam logic CMD_PRESS   = 1'b1;
    localparam int unsigned RING_DEPTH = kpdt_pkg::QUEUE_DEPTH;
    localparam int SETTLE_CYCLES  = 100;
    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct {
        logic [4:0]  col;
        logic [3:0]  row;
        logic [4:0]  layer;
        logic        done;
        logic [31:0] start;
        logic [31:0] gap;
        logic [31:0] hold;
    } queued_press_t;

    logic clk = 1'b0;
    logic rst_n;

    kpdt_evt_if evt();
    kpdt_tap_if tap();
    kpdt_cfg_if cfg();

    key_press_duration_tracker dut (
        .clk   (clk),
        .rst_n (rst_n),
        .evt   (evt),
        .tap   (tap),
        .cfg   (cfg)
    );

    // tracking model state
    queued_press_t press_ring[RING_DEPTH];
    int unsigned   ring_head = 0;
    int unsigned   ring_count = 0;
    logic [31:0]   last_press_ms = '0;
    logic          any_event_seen = 1'b0;
    logic [31:0]   hold_limit_ms = kpdt_pkg::MAX_HOLD_RESET;

    kpdt_pkg::result_t due_taps[$];
    kpdt_pkg::result_t due_front;

    logic [8:0]  held_keys[$];
    logic [31:0] typing_ms;
    int unsigned sender_idle_pct = 0;
    int unsigned receiver_stall_pct = 0;
    int          fail_count = 0;
    int          events_sent = 0;
    int          taps_seen = 0;
    int          timeouts_seen = 0;
    int          drops_seen = 0;
    int          quiet_cycles = 0;

    always #4 clk = ~clk;

    function automatic void track_key_event(input logic is_press, input logic [4:0] col,
                                            input logic [3:0] row, input logic [4:0] layer,
                                            input logic [31:0] now);
        kpdt_pkg::result_t batch[$];
        kpdt_pkg::result_t r;
        int unsigned       i;
        int unsigned       slot;
        logic [31:0]       age;
        logic [31:0]       held;
        logic [31:0]       gap;
        if (!any_event_seen)
        begin
            any_event_seen = 1'b1;
            last_press_ms = now;
        end
        // release marks the oldest open press of that key
        if (!is_press)
        begin
            for (i = 0; i < ring_count; i++)
            begin
                slot = (ring_head + i) % RING_DEPTH;
                if (!press_ring[slot].done && press_ring[slot].col == col
                    && press_ring[slot].row == row)
                begin
                    press_ring[slot].done = 1'b1;
                    press_ring[slot].hold = now - press_ring[slot].start;
                    break;
                end
            end
        end
        while (ring_count > 0)
        begin
            slot = ring_head;
            age = now - press_ring[slot].start;
            if (!press_ring[slot].done && age <= hold_limit_ms)
                break;
            held = press_ring[slot].done ? press_ring[slot].hold : age;
            r.col   = press_ring[slot].col;
            r.row   = press_ring[slot].row;
            r.layer = press_ring[slot].layer;
            r.hold  = held;
            r.gap   = press_ring[slot].gap;
            r.kind  = (held > hold_limit_ms) ? kpdt_pkg::KIND_TIMEOUT : kpdt_pkg::KIND_TAP;
            r.last  = 1'b0;
            batch.insert(batch.size(), r);
            ring_head = (ring_head + 1) % RING_DEPTH;
            ring_count--;
        end
        if (is_press)
        begin
            gap = now - last_press_ms;
            last_press_ms = now;
            if (ring_count >= RING_DEPTH)
            begin
                r.col   = col;
                r.row   = row;
                r.layer = layer;
                r.hold  = '0;
                r.gap   = gap;
                r.kind  = kpdt_pkg::KIND_DROP;
                r.last  = 1'b0;
                batch.insert(batch.size(), r);
            end
            else
            begin
                slot = (ring_head + ring_count) % RING_DEPTH;
                press_ring[slot] = '{col, row, layer, 1'b0, now, gap, 32'd0};
                ring_count++;
            end
        end
        if (batch.size() > 0)
            batch[batch.size() - 1].last = 1'b1;
        foreach (batch[k])
            due_taps.insert(due_taps.size(), batch[k]);
    endfunction

    task automatic send_event(input logic cmd, input logic [4:0] col, input logic [3:0] row,
                              input logic [4:0] layer, input logic [31:0] now);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            evt.valid = 1'b0;
            @(negedge clk);
        end
        evt.valid     = 1'b1;
        evt.cmd       = cmd;
        evt.key_col   = col;
        evt.key_row   = row;
        evt.key_layer = layer;
        evt.now_ms    = now;
        do @(posedge clk); while (!evt.ready);
        track_key_event(cmd == CMD_PRESS, col, row, layer, now);
        events_sent++;
    endtask

    // block is idle once every word is back and the tail of a scan has passed
    task automatic settle_block();
        @(negedge clk);
        evt.valid = 1'b0;
        while (due_taps.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_hold_limit(input logic [31:0] value);
        settle_block();
        cfg.valid = 1'b1;
        cfg.data  = value;
        do @(posedge clk); while (!cfg.ready);
        hold_limit_ms = value;
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    task automatic advance_typing_clock();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 5)
            typing_ms = typing_ms;
        else if (roll < 70)
            typing_ms = typing_ms + $urandom_range(1, 400);
        else if (roll < 92)
            typing_ms = typing_ms + $urandom_range(400, 2500);
        else
            typing_ms = typing_ms + $urandom();
    endtask

    // presses and releases of held keys, with some stray releases mixed in
    task automatic run_typing(input int unsigned n_events, input int unsigned press_pct);
        int unsigned roll;
        int unsigned idx;
        logic [8:0]  pick;
        logic [4:0]  col;
        logic [3:0]  row;
        repeat (n_events)
        begin
            advance_typing_clock();
            roll = $urandom_range(99);
            if (roll >= 92)
            begin
                send_event(CMD_RELEASE, 5'($urandom_range(31)), 4'($urandom_range(15)),
                           5'($urandom_range(31)), typing_ms);
            end
            else if (roll < press_pct || held_keys.size() == 0)
            begin
                col = 5'($urandom_range(31));
                row = 4'($urandom_range(15));
                held_keys.insert(held_keys.size(), {row, col});
                if (held_keys.size() > 40)
                    held_keys.delete(0);
                send_event(CMD_PRESS, col, row, 5'($urandom_range(31)), typing_ms);
            end
            else
            begin
                idx = $urandom_range(held_keys.size() - 1);
                pick = held_keys[idx];
                held_keys.delete(idx);
                send_event(CMD_RELEASE, pick[4:0], pick[8:5], 5'($urandom_range(31)),
                           typing_ms);
            end
        end
    endtask

    task automatic test_first_event_and_taps();
        logic [31:0] base;
        base = 32'hFFFF_FF00;
        // stray release as first event, timestamps wrap past zero
        send_event(CMD_RELEASE, 5'd5, 4'd3, 5'd7, base);
        send_event(CMD_PRESS, 5'd31, 4'd15, 5'd31, base + 100);
        send_event(CMD_PRESS, 5'd0, 4'd0, 5'd0, base + 300);
        send_event(CMD_RELEASE, 5'd0, 4'd0, 5'd9, base + 350);
        // late release of the head, then the finished entry behind it
        send_event(CMD_RELEASE, 5'd31, 4'd15, 5'd0, base + 1200);
        // same key twice: release hits the older one
        send_event(CMD_PRESS, 5'd10, 4'd7, 5'd16, base + 1300);
        send_event(CMD_PRESS, 5'd10, 4'd7, 5'd1, base + 1310);
        send_event(CMD_RELEASE, 5'd10, 4'd7, 5'd2, base + 1400);
        // unreleased head times out
        send_event(CMD_PRESS, 5'd21, 4'd10, 5'd10, base + 2400);
        typing_ms = base + 2400;
    endtask

    task automatic test_queue_overflow();
        int unsigned i;
        write_hold_limit(32'hFFFF_FFFF);
        for (i = 0; i < RING_DEPTH; i++)
        begin
            typing_ms = typing_ms + 1;
            send_event(CMD_PRESS, 5'(2 * i), 4'(i), 5'(31 - i), typing_ms);
        end
    endtask

    task automatic test_zero_limit_churn();
        write_hold_limit(32'd0);
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        run_typing(45, 50);
    endtask

    task automatic test_sender_gaps();
        write_hold_limit(32'($urandom_range(200, 3000)));
        sender_idle_pct = 58;
        receiver_stall_pct = 0;
        run_typing(45, 55);
    endtask

    task automatic test_receiver_stalls();
        write_hold_limit(32'hFFFF_FFFF);
        sender_idle_pct = 0;
        receiver_stall_pct = 58;
        run_typing(45, 70);
    endtask

    task automatic test_mixed_backpressure();
        write_hold_limit(32'($urandom_range(50, 800)));
        sender_idle_pct = 30;
        receiver_stall_pct = 30;
        run_typing(50, 55);
    endtask

    initial
    begin
        tap.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            tap.ready = ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && tap.valid && tap.ready)
        begin
            if (due_taps.size() == 0)
            begin
                $error("unexpected word: col %0d row %0d kind %0d",
                       tap.tap_col, tap.tap_row, tap.kind);
                fail_count++;
            end
            else
            begin
                due_front = due_taps[0];
                due_taps.delete(0);
                taps_seen++;
                if (due_front.kind == kpdt_pkg::KIND_TIMEOUT)
                    timeouts_seen++;
                if (due_front.kind == kpdt_pkg::KIND_DROP)
                    drops_seen++;
                if (tap.tap_col !== due_front.col)
                begin
                    $error("tap_col: expected %0d, got %0d", due_front.col, tap.tap_col);
                    fail_count++;
                end
                if (tap.tap_row !== due_front.row)
                begin
                    $error("tap_row: expected %0d, got %0d", due_front.row, tap.tap_row);
                    fail_count++;
                end
                if (tap.tap_layer !== due_front.layer)
                begin
                    $error("tap_layer: expected %0d, got %0d", due_front.layer,
                           tap.tap_layer);
                    fail_count++;
                end
                if (tap.hold_ms !== due_front.hold)
                begin
                    $error("hold_ms: expected %0d, got %0d", due_front.hold, tap.hold_ms);
                    fail_count++;
                end
                if (tap.gap_ms !== due_front.gap)
                begin
                    $error("gap_ms: expected %0d, got %0d", due_front.gap, tap.gap_ms);
                    fail_count++;
                end
                if (tap.kind !== due_front.kind)
                begin
                    $error("kind: expected %0d, got %0d", due_front.kind, tap.kind);
                    fail_count++;
                end
                if (tap.last !== due_front.last)
                begin
                    $error("last: expected %0d, got %0d", due_front.last, tap.last);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (evt.valid && evt.ready) || (tap.valid && tap.ready)
            || (cfg.valid && cfg.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("key_press_duration_tracker regression: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n         = 1'b0;
        evt.valid     = 1'b0;
        evt.cmd       = CMD_RELEASE;
        evt.key_col   = '0;
        evt.key_row   = '0;
        evt.key_layer = '0;
        evt.now_ms    = '0;
        cfg.valid     = 1'b0;
        cfg.data      = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_first_event_and_taps();
        test_queue_overflow();
        test_zero_limit_churn();
        test_sender_gaps();
        test_receiver_stalls();
        test_mixed_backpressure();
        settle_block();

        $display("covered %0d key events and %0d result words (%0d timeouts, %0d drops)",
                 events_sent, taps_seen, timeouts_seen, drops_seen);
        $display("hold limits 0, 1000, all ones and random; idle, gaps, stalls and both");
        if (fail_count == 0 && due_taps.size() == 0)
            $display("key_press_duration_tracker regression: pass");
        else
            $display("key_press_duration_tracker regression: fail");
        $finish;
    end

endmodule
